FILE: hdl/tcw_pkg.sv
package tcw_pkg;

    // Opcodes of the input item.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Character codes and the attribute that the screen comes out of reset with.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h0F;

    // Commands handed from the front end to the back end.
    localparam int         CMD_W         = 3;
    localparam logic [2:0] CMD_NOP       = 3'd0;
    localparam logic [2:0] CMD_PRINT     = 3'd1;
    localparam logic [2:0] CMD_NEWLINE   = 3'd2;
    localparam logic [2:0] CMD_BACKSPACE = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;
    localparam logic [2:0] CMD_READ      = 3'd5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [CMD_W-1:0] kind;
        logic [7:0]       chr;
        logic [10:0]      index;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

FILE: hdl/tcw_front.sv
module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [7:0]         i_char_code,
    input  logic [10:0]        i_cell_index,
    input  logic               i_enable,
    input  tcw_pkg::t_q_status i_q_status,
    output logic               o_push,
    output tcw_pkg::t_cmd      o_cmd
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;

    logic in_range;

    assign o_in_ready = i_enable && !i_q_status.full;
    assign o_push     = i_in_valid && o_in_ready;
    assign in_range   = 32'(i_cell_index) < 32'(CELL_COUNT);

    always_comb begin
        o_cmd.chr   = i_char_code;
        o_cmd.index = i_cell_index;
        unique case (i_opcode)
            OP_PUT: begin
                priority if (i_char_code == CH_NEWLINE) begin
                    o_cmd.kind = CMD_NEWLINE;
                end else if (i_char_code == CH_BACKSPACE) begin
                    o_cmd.kind = CMD_BACKSPACE;
                end else begin
                    o_cmd.kind = CMD_PRINT;
                end
            end
            OP_CLEAR: o_cmd.kind = CMD_CLEAR;
            // A read beyond the screen answers zero and touches nothing.
            OP_READ:  o_cmd.kind = in_range ? CMD_READ : CMD_NOP;
            default:  o_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

FILE: hdl/tcw_queue.sv
module tcw_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tcw_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output tcw_pkg::t_cmd      o_cmd,
    output tcw_pkg::t_q_status o_status
);
    import tcw_pkg::*;

    t_cmd                   r_slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic [QUEUE_PTR_W:0]   n_count;

    assign o_cmd           = r_slots[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: hdl/tcw_back.sv
module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_attr,
    input  tcw_pkg::t_cmd      i_cmd,
    input  tcw_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_init_done,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_cell_value,
    output logic [4:0]         o_cursor_row,
    output logic [6:0]         o_cursor_col
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] SCROLL_N  = ADDR_W'(COLUMNS * (ROWS - 1));
    localparam logic [ADDR_W-1:0] BOTTOM    = ADDR_W'(COLUMNS * (ROWS - 1));
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_SCROLL = 2'd2;
    localparam logic [1:0] ST_FILL   = 2'd3;

    logic [15:0]       r_mem [CELL_COUNT];
    logic [15:0]       r_rd_data;

    logic [1:0]        r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_fill_addr, n_fill_addr;
    logic [15:0]       r_fill_data, n_fill_data;
    logic              r_fill_report, n_fill_report;
    logic              r_init_done, n_init_done;
    logic              r_cp_valid, n_cp_valid;
    logic [ADDR_W-1:0] r_cp_addr;
    logic              r_out_valid;
    logic [15:0]       r_out_value;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;

    logic              slot_free;
    logic              line_feed;
    logic              load_out;
    logic [15:0]       out_value;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign slot_free    = !r_out_valid || i_out_ready;
    assign o_init_done  = r_init_done;
    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_value;
    assign o_cursor_row = 5'(r_out_row);
    assign o_cursor_col = 7'(r_out_col);

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_col         = r_col;
        n_base        = r_base;
        n_cnt         = r_cnt;
        n_fill_addr   = r_fill_addr;
        n_fill_data   = r_fill_data;
        n_fill_report = r_fill_report;
        n_init_done   = r_init_done;
        o_pop         = 1'b0;
        line_feed     = 1'b0;
        load_out      = 1'b0;
        out_value     = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty && slot_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_PRINT: begin
                            wr_en   = 1'b1;
                            wr_addr = r_base + ADDR_W'(r_col);
                            wr_data = {i_attr, i_cmd.chr};
                            if (r_col == COL_LAST) begin
                                n_col     = '0;
                                line_feed = 1'b1;
                            end else begin
                                n_col    = r_col + 1'b1;
                                load_out = 1'b1;
                            end
                        end
                        CMD_NEWLINE: begin
                            n_col     = '0;
                            line_feed = 1'b1;
                        end
                        CMD_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                            end
                            wr_en    = 1'b1;
                            wr_addr  = r_base + ADDR_W'(n_col);
                            wr_data  = {i_attr, CH_SPACE};
                            load_out = 1'b1;
                        end
                        CMD_CLEAR: begin
                            n_row         = '0;
                            n_col         = '0;
                            n_base        = '0;
                            n_fill_addr   = '0;
                            n_fill_data   = {i_attr, CH_SPACE};
                            n_fill_report = 1'b1;
                            n_state       = ST_FILL;
                        end
                        CMD_READ: begin
                            rd_en   = 1'b1;
                            rd_addr = ADDR_W'(i_cmd.index);
                            n_state = ST_READ;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                    // Moving off the last row scrolls; the cursor stays on the last row.
                    if (line_feed) begin
                        if (r_row == ROW_LAST) begin
                            n_cnt   = '0;
                            n_state = ST_SCROLL;
                        end else begin
                            n_row    = r_row + 1'b1;
                            n_base   = r_base + COL_STEP;
                            load_out = 1'b1;
                        end
                    end
                end
            end
            ST_READ: begin
                load_out  = 1'b1;
                out_value = r_rd_data;
                n_state   = ST_IDLE;
            end
            ST_SCROLL: begin
                // Each cell is read one row down and written back in the following cycle.
                if (r_cnt != SCROLL_N) begin
                    rd_en   = 1'b1;
                    rd_addr = r_cnt + COL_STEP;
                    n_cnt   = r_cnt + 1'b1;
                end else begin
                    n_fill_addr   = BOTTOM;
                    n_fill_data   = {i_attr, CH_SPACE};
                    n_fill_report = 1'b1;
                    n_state       = ST_FILL;
                end
            end
            ST_FILL: begin
                wr_en   = 1'b1;
                wr_addr = r_fill_addr;
                wr_data = r_fill_data;
                if (r_fill_addr == LAST_ADDR) begin
                    n_state     = ST_IDLE;
                    n_init_done = 1'b1;
                    load_out    = r_fill_report;
                end else begin
                    n_fill_addr = r_fill_addr + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (r_cp_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_cp_addr;
            wr_data = r_rd_data;
        end
    end

    assign n_cp_valid = (r_state == ST_SCROLL) && (r_cnt != SCROLL_N);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_FILL;
            r_row         <= '0;
            r_col         <= '0;
            r_base        <= '0;
            r_cnt         <= '0;
            r_fill_addr   <= '0;
            r_fill_data   <= {ATTR_RESET, CH_SPACE};
            r_fill_report <= 1'b0;
            r_init_done   <= 1'b0;
            r_cp_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_row         <= n_row;
            r_col         <= n_col;
            r_base        <= n_base;
            r_cnt         <= n_cnt;
            r_fill_addr   <= n_fill_addr;
            r_fill_data   <= n_fill_data;
            r_fill_report <= n_fill_report;
            r_init_done   <= n_init_done;
            r_cp_valid    <= n_cp_valid;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_cnt;
        if (load_out) begin
            r_out_value <= out_value;
            r_out_row   <= n_row;
            r_out_col   <= n_col;
        end
    end

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < 32'(COLUMNS)) && (32'(r_row) < 32'(ROWS)))
        else $error("cursor outside the screen");

    a_base_tracks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_base) == 32'(r_row) * 32'(COLUMNS))
        else $error("line base does not match cursor row");

    a_copy_after_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> $past(r_state) == ST_SCROLL)
        else $error("copy write outside a scroll");

    a_result_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_state == ST_IDLE) && r_init_done)
        else $error("result issued while an operation is still running");
`endif

endmodule

FILE: hdl/text_console_writer.sv
// Text console of ROWS x COLUMNS 16-bit cells (attribute high byte, character low byte)
// with a cursor. Each beat on the input channel gives exactly one result beat, in order.
// Print, newline, backspace, the unused opcode and out-of-range reads that do not scroll
// leave the two-entry command queue and load their result on the same edge, so such
// items stream at one per cycle while the result slot is free; an in-range read passes
// through a read state before its result loads. The screen store has a single write
// port, which sets the long cases: a clear writes every cell in turn, and an item that
// moves the cursor past the last row scrolls by copying each cell one row up and then
// blanking the bottom row. After reset a clearing pass fills the screen with blanks in
// attribute 0x0F, during which o_in_ready stays low. The attribute register affects only
// cells written after the write.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_cell_value,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);
    import tcw_pkg::*;

    logic [7:0] r_attr;
    logic       push;
    logic       pop;
    logic       init_done;
    t_cmd       front_cmd;
    t_cmd       queue_cmd;
    t_q_status  q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_data;
        end
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_enable     (init_done),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    tcw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_attr       (r_attr),
        .i_cmd        (queue_cmd),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_init_done  (init_done),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cell_value (o_cell_value),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

endmodule

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int SCR_COLS  = 80;
    localparam int SCR_ROWS  = 25;
    localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  chr;
        logic [10:0] index;
        logic        drain;
    } t_console_op;

    typedef struct packed {
        logic [15:0] value;
        logic [4:0]  row;
        logic [6:0]  col;
    } t_console_view;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_opcode = '0;
    logic [7:0]  i_char_code = '0;
    logic [10:0] i_cell_index = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_cell_value;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = '0;

    text_console_writer #(
        .COLUMNS(SCR_COLS),
        .ROWS   (SCR_ROWS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_char_code (i_char_code),
        .i_cell_index(i_cell_index),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cell_value(o_cell_value),
        .o_cursor_row(o_cursor_row),
        .o_cursor_col(o_cursor_col),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the console.
    logic [15:0] screen_m [SCR_CELLS];
    int unsigned row_m;
    int unsigned col_m;
    logic [7:0]  attr_m;

    t_console_op   console_cmds[$];
    t_console_view predicted_views[$];
    t_console_op   cur_op;
    int            n_accepted = 0;
    int            n_results = 0;
    int            n_errors = 0;
    int            n_pushed = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    function automatic void blank_screen();
        for (int i = 0; i < SCR_CELLS; i++) screen_m[i] = {attr_m, CH_SPACE};
        row_m = 0;
        col_m = 0;
    endfunction

    task automatic console_apply(input t_console_op op, output t_console_view res);
        res = '0;
        case (op.opcode)
            OP_PUT: begin
                if (op.chr == CH_NEWLINE) begin
                    col_m = 0;
                    row_m++;
                end else if (op.chr == CH_BACKSPACE) begin
                    if (col_m > 0) col_m--;
                    screen_m[row_m * SCR_COLS + col_m] = {attr_m, CH_SPACE};
                end else begin
                    screen_m[row_m * SCR_COLS + col_m] = {attr_m, op.chr};
                    col_m++;
                end
                if (col_m >= SCR_COLS) begin
                    col_m = 0;
                    row_m++;
                end
                if (row_m >= SCR_ROWS) begin
                    for (int i = 0; i < SCR_COLS * (SCR_ROWS - 1); i++)
                        screen_m[i] = screen_m[i + SCR_COLS];
                    for (int i = 0; i < SCR_COLS; i++)
                        screen_m[(SCR_ROWS - 1) * SCR_COLS + i] = {attr_m, CH_SPACE};
                    row_m = SCR_ROWS - 1;
                end
            end
            OP_CLEAR: blank_screen();
            OP_READ: begin
                if (op.index < SCR_CELLS) res.value = screen_m[op.index];
            end
            default: ;
        endcase
        res.row = row_m[4:0];
        res.col = col_m[6:0];
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Driver: presents queued commands and predicts each one as its beat is taken.
    always @(posedge i_clk) begin
        t_console_view view;
        logic          can_load;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            can_load = !i_in_valid || o_in_ready;
            if (i_in_valid && o_in_ready) begin
                console_apply(cur_op, view);
                predicted_views.push_back(view);
                n_accepted <= n_accepted + 1;
            end
            if (can_load) begin
                // A drain command is held back until every earlier result has come out.
                if (console_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct &&
                    !(console_cmds[0].drain && (i_in_valid || n_accepted != n_results))) begin
                    cur_op = console_cmds.pop_front();
                    i_in_valid   <= 1'b1;
                    i_opcode     <= cur_op.opcode;
                    i_char_code  <= cur_op.chr;
                    i_cell_index <= cur_op.index;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_console_view want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results <= n_results + 1;
                if (n_results >= n_accepted || predicted_views.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%t unexpected result: expected none, got value %h row %0d col %0d",
                                 $realtime, o_cell_value, o_cursor_row, o_cursor_col);
                end else begin
                    want = predicted_views.pop_front();
                    if (o_cell_value !== want.value) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%t cell_value mismatch: expected %h, got %h",
                                     $realtime, want.value, o_cell_value);
                    end
                    if (o_cursor_row !== want.row) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%t cursor_row mismatch: expected %0d, got %0d",
                                     $realtime, want.row, o_cursor_row);
                    end
                    if (o_cursor_col !== want.col) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%t cursor_col mismatch: expected %0d, got %0d",
                                     $realtime, want.col, o_cursor_col);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_cmd(input logic [1:0] opcode, input logic [7:0] chr,
                            input logic [10:0] index, input logic drain);
        t_console_op op;
        op.opcode = opcode;
        op.chr    = chr;
        op.index  = index;
        op.drain  = drain;
        console_cmds.push_back(op);
        n_pushed++;
    endtask

    // Reads lean toward the bottom rows, where recent text ends up after a scroll.
    function automatic logic [10:0] pick_cell();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 11'($urandom_range(1999, 1920));
        if (r < 60) return 11'($urandom_range(1919, 1840));
        if (r < 85) return 11'($urandom_range(1999, 0));
        if (r < 95) return 11'($urandom_range(159, 0));
        return 11'($urandom_range(2047, 2000));
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 30) return 8'($urandom_range(126, 32));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic rand_drain();
        return ($urandom_range(199) == 0);
    endfunction

    task automatic put_key(input logic [7:0] chr);
        push_cmd(OP_PUT, chr, 11'($urandom_range(2047)), rand_drain());
    endtask

    task automatic read_cell(input logic [10:0] index);
        push_cmd(OP_READ, 8'($urandom_range(255)), index, rand_drain());
    endtask

    task automatic emit_text_line();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 60) len = $urandom_range(10);
        else if (r < 90) len = $urandom_range(79, 10);
        else len = $urandom_range(130, 80);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 1)) put_key(CH_BACKSPACE);
        end
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 8) put_key(CH_BACKSPACE);
            else put_key(pick_char());
            if ($urandom_range(99) < 15) read_cell(pick_cell());
        end
        if ($urandom_range(9) != 0) put_key(CH_NEWLINE);
        if ($urandom_range(99) < 3)
            push_cmd(OP_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)), rand_drain());
        if ($urandom_range(99) < 2)
            push_cmd(OP_NONE, 8'($urandom_range(255)), 11'($urandom_range(2047)), rand_drain());
    endtask

    task automatic fill_random(input int count);
        int start;
        start = n_pushed;
        // Make sure every phase has at least one full drain of the pipeline.
        push_cmd(OP_READ, 8'h00, pick_cell(), 1'b1);
        while (n_pushed - start < count) emit_text_line();
    endtask

    task automatic fill_directed();
        read_cell(11'd0);
        read_cell(11'd1999);
        read_cell(11'd2000);
        read_cell(11'd2047);
        put_key(8'h00);
        put_key(8'hFF);
        put_key(8'h80);
        put_key(8'h7F);
        put_key(CH_BACKSPACE);
        read_cell(11'd1);
        read_cell(11'd2);
        read_cell(11'd3);
        put_key(CH_NEWLINE);
        put_key(CH_BACKSPACE);
        put_key(8'h41);
        read_cell(11'd80);
        read_cell(11'd0);
        push_cmd(OP_NONE, 8'hFF, 11'h7FF, 1'b0);
        push_cmd(OP_CLEAR, 8'hAA, 11'h555, 1'b0);
        read_cell(11'd1);
        put_key(CH_NEWLINE);
        read_cell(11'd81);
    endtask

    // Waits until the block has nothing in flight, then idles before returning.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (console_cmds.size() != 0 || i_in_valid || n_results != n_accepted);
        repeat (2 * SCR_CELLS + 64) @(negedge i_clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        attr_m = value;
    endtask

    initial begin
        logic [7:0] attrs [4];
        int         send_pcts [4];
        int         recv_pcts [4];
        attrs     = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255))};
        send_pcts = '{0, 67, 0, 7};
        recv_pcts = '{0, 0, 67, 7};
        attr_m = ATTR_RESET;
        blank_screen();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fill_directed();
        wait_idle();
        for (int p = 0; p < 4; p++) begin
            write_attribute(attrs[p]);
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            fill_random(350);
            wait_idle();
        end

        if (n_errors == 0 && predicted_views.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Even if every item scrolled or cleared the screen, this timeout leaves ample margin.
    initial begin
        #200_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
